// ===== hw/rtl/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
// No dependencies; used by bra_ctrl, bra_dpath and bitmap_run_allocator.
`default_nettype none

package bra_pkg;

    localparam int MAP_BYTES = 128;
    localparam int WORD_W    = 32;
    localparam int MAP_WORDS = MAP_BYTES / (WORD_W / 8);
    localparam int WORD_AW   = $clog2(MAP_WORDS);

    // register index, decoded from paddr[2]
    localparam logic REG_BYTES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        MODE_TEST  = 2'd0,
        MODE_SCAN  = 2'd1,
        MODE_SET   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_NONE    = 3'd2,
        STAT_OFF_END = 3'd3,
        STAT_RANGE   = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic quick;
        logic clr;
        logic rd;
        logic scan_init;
        logic scan_run;
        logic res_rd;
        logic wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  quick;
        logic  scan_done;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/bra_ctrl.sv =====
// Controller FSM for the bitmap run allocator: sequences item load, memory
// access, scan and result hand-off. Depends on bra_pkg.
`default_nettype none

module bra_ctrl
    import bra_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_OP   = 5'b00010,
        ST_RD   = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_OP;
                end
            end
            ST_OP: begin
                if (i_sts.quick) begin
                    o_cmd.quick = 1'b1;
                    o_cmd.clr   = (i_sts.mode == MODE_CLEAR);
                    n_state     = ST_DONE;
                end else if (i_sts.mode == MODE_SCAN) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.res_rd = 1'b1;
                o_cmd.wr     = (i_sts.mode == MODE_SET);
                n_state      = ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bra_dpath.sv =====
// Datapath for the bitmap run allocator: item registers, bitmap word memory
// with valid bits, word-at-a-time run search and result registers.
// Depends on bra_pkg.
`default_nettype none

module bra_dpath
    import bra_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [7:0]  i_len,
    input  wire  [1:0]  i_mode,
    input  wire  [10:0] i_bit_pos,
    input  wire  [7:0]  i_value,
    input  wire  [10:0] i_run_length,
    input  wire         i_out_stall,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [9:0]  o_found_index,
    output logic        o_bit_value,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);

    // latched item
    t_mode       r_mode;
    logic [10:0] r_bit_pos;
    logic [7:0]  r_value;
    logic [10:0] r_run_length;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= t_mode'(i_mode);
            r_bit_pos    <= i_bit_pos;
            r_value      <= i_value;
            r_run_length <= i_run_length;
        end
    end

    // quick checks
    logic    range_err, val_bad, len_zero, quick;
    t_status quick_status;

    assign range_err = (r_bit_pos[10:3] >= i_len);
    assign val_bad   = |r_value[7:1];
    assign len_zero  = (i_len == 8'd0);

    always_comb begin
        quick        = 1'b1;
        quick_status = STAT_OK;
        unique case (r_mode)
            MODE_TEST: begin
                quick        = range_err;
                quick_status = STAT_RANGE;
            end
            MODE_SET: begin
                quick        = range_err | val_bad;
                quick_status = range_err ? STAT_RANGE : STAT_OK;
            end
            MODE_SCAN: begin
                quick        = val_bad | len_zero;
                quick_status = val_bad ? STAT_INVALID : STAT_NONE;
            end
            MODE_CLEAR: begin
                quick        = 1'b1;
                quick_status = STAT_OK;
            end
            default: begin
                quick        = 1'b1;
                quick_status = STAT_OK;
            end
        endcase
    end

    // bitmap memory
    logic [WORD_W-1:0]    r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_wvalid;
    logic [WORD_W-1:0]    r_rdata;
    logic                 r_rvalid;
    logic [WORD_AW-1:0]   r_rd_word, r_ev_word;
    logic [WORD_AW-1:0]   rd_addr, item_addr;
    logic                 rd_en;
    logic [WORD_W-1:0]    rd_word, set_word;

    assign item_addr = r_bit_pos[WORD_AW+4:5];
    assign rd_en     = i_cmd.rd | i_cmd.scan_init | i_cmd.scan_run;

    always_comb begin
        if (i_cmd.scan_run) begin
            rd_addr = r_rd_word;
        end else if (i_cmd.scan_init) begin
            rd_addr = '0;
        end else begin
            rd_addr = item_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rvalid <= r_wvalid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[item_addr] <= set_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_cmd.clr) begin
            r_wvalid <= '0;
        end else if (i_cmd.wr) begin
            r_wvalid[item_addr] <= 1'b1;
        end
    end

    assign rd_word = r_rvalid ? r_rdata : '0;

    always_comb begin
        set_word                 = rd_word;
        set_word[r_bit_pos[4:0]] = r_value[0];
    end

    // scan word pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_rd_word <= WORD_AW'(1);
            r_ev_word <= '0;
        end else if (i_cmd.scan_run) begin
            r_rd_word <= r_rd_word + WORD_AW'(1);
            r_ev_word <= r_rd_word;
        end
    end

    // run search over one word
    logic [7:0]        len_m1;
    logic [WORD_AW-1:0] last_w;
    logic              ev_last, last_bit;
    logic [WORD_W-1:0] ev_raw, ev_mask, ev_m, ok;
    logic [WORD_W-1:0] a_lvl [6];
    logic [WORD_W-1:0] a_sel;
    logic [2:0]        k_sel;
    logic [4:0]        d_sh;
    logic              rl_zero, rl_small;
    logic [5:0]        lead_run, top_run;
    logic [4:0]        ok_pos;
    logic              any_ok, carry_ok, ev_found;
    logic [11:0]       carry_sum;
    logic [10:0]       r_c;
    logic [9:0]        r_s;
    logic [9:0]        found_pos;

    assign len_m1   = i_len - 8'd1;
    assign last_w   = len_m1[6:2];
    assign ev_last  = (r_ev_word == last_w);
    assign ev_raw   = r_value[0] ? rd_word : ~rd_word;
    assign last_bit = ev_raw[{len_m1[1:0], 3'b111}];

    always_comb begin
        if (ev_last) begin
            ev_mask = {{8{len_m1[1:0] == 2'd3}}, {8{len_m1[1]}},
                       {8{len_m1[1:0] != 2'd0}}, 8'hff};
        end else begin
            ev_mask = '1;
        end
    end

    assign ev_m = ev_raw & ev_mask;

    always_comb begin
        a_lvl[0] = ev_m;
        for (int i = 0; i < 5; i++) begin
            a_lvl[i+1] = a_lvl[i] & (a_lvl[i] >> (1 << i));
        end
    end

    assign rl_zero  = (r_run_length == 11'd0);
    assign rl_small = (r_run_length <= 11'd32);

    always_comb begin
        if (r_run_length[5]) begin
            k_sel = 3'd5;
            d_sh  = 5'd0;
        end else if (r_run_length[4]) begin
            k_sel = 3'd4;
            d_sh  = {1'b0, r_run_length[3:0]};
        end else if (r_run_length[3]) begin
            k_sel = 3'd3;
            d_sh  = {2'b0, r_run_length[2:0]};
        end else if (r_run_length[2]) begin
            k_sel = 3'd2;
            d_sh  = {3'b0, r_run_length[1:0]};
        end else if (r_run_length[1]) begin
            k_sel = 3'd1;
            d_sh  = {4'b0, r_run_length[0]};
        end else begin
            k_sel = 3'd0;
            d_sh  = 5'd0;
        end
    end

    assign a_sel = a_lvl[k_sel];

    always_comb begin
        if (rl_zero) begin
            ok = ev_m;
        end else if (rl_small) begin
            ok = a_sel & (a_sel >> d_sh);
        end else begin
            ok = '0;
        end
    end

    always_comb begin
        lead_run = 6'd32;
        top_run  = 6'd32;
        ok_pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!ev_m[i]) lead_run = 6'(i);
            if (ok[i]) ok_pos = 5'(i);
        end
        for (int i = 0; i < WORD_W; i++) begin
            if (!ev_m[i]) top_run = 6'(WORD_W - 1 - i);
        end
    end

    assign any_ok    = |ok;
    assign carry_sum = {1'b0, r_c} + {6'b0, lead_run};
    assign carry_ok  = !rl_zero && (carry_sum >= {1'b0, r_run_length});
    assign ev_found  = carry_ok | any_ok;

    always_comb begin
        if (carry_ok) begin
            found_pos = r_s;
        end else if (rl_zero) begin
            found_pos = {r_ev_word, ok_pos[4:3], 3'b000};
        end else begin
            found_pos = {r_ev_word, ok_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_c <= '0;
            r_s <= '0;
        end else if (i_cmd.scan_run && !ev_found) begin
            if (&ev_m) begin
                r_c <= r_c + 11'd32;
            end else begin
                r_c <= {5'b0, top_run};
                r_s <= {r_ev_word, 5'b0} + {4'b0, 6'd32 - top_run};
            end
        end
    end

    // result and output registers
    t_status    r_res_status;
    logic [9:0] r_res_found;
    logic       r_res_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.quick) begin
            r_res_status <= quick_status;
            r_res_found  <= '0;
            r_res_bit    <= 1'b0;
        end else if (i_cmd.res_rd) begin
            r_res_status <= STAT_OK;
            r_res_found  <= '0;
            r_res_bit    <= (r_mode == MODE_TEST) & rd_word[r_bit_pos[4:0]];
        end else if (i_cmd.scan_run && (ev_found || ev_last)) begin
            r_res_bit <= 1'b0;
            if (ev_found) begin
                r_res_status <= STAT_OK;
                r_res_found  <= found_pos;
            end else begin
                r_res_status <= last_bit ? STAT_OFF_END : STAT_NONE;
                r_res_found  <= '0;
            end
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= r_res_status;
            o_found_index <= r_res_found;
            o_bit_value   <= r_res_bit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.mode      = r_mode;
    assign o_sts.quick     = quick;
    assign o_sts.scan_done = ev_found | ev_last;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_run_allocator.sv =====
// Top level of the bitmap run allocator: APB register, controller and
// datapath. Depends on bra_pkg, bra_ctrl and bra_dpath.
//
//   port group    direction  handshake                    payload
//   input item    in         i_in_valid / o_in_stall      i_mode, i_bit_pos, i_value,
//                                                          i_run_length
//   result        out        o_out_valid / i_out_stall    o_status, o_found_index,
//                                                          o_bit_value
//   config        in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Test and set go through ST_OP, ST_RD and ST_DONE; clear and rejected items go
// from ST_OP straight to ST_DONE, which hands off the result. Scan reads one 32-bit
// map word per cycle from the word memory until a run is found or the last word in use.
// Reset is synchronous; the map reads as zeros after reset (per-word valid
// bits), bytes_in_use resets to 128. A stalled result holds in the output
// register while the next item is already accepted and worked on.
`default_nettype none

module bitmap_run_allocator
    import bra_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_mode,
    input  wire  [10:0] i_bit_pos,
    input  wire  [7:0]  i_value,
    input  wire  [10:0] i_run_length,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic [9:0]  o_found_index,
    output logic        o_bit_value,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_bytes_in_use;
    logic [7:0] act_len;
    logic       cfg_wr;
    t_cmd       cmd;
    t_sts       sts;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_BYTES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_use <= 8'(MAP_BYTES);
        end else if (cfg_wr) begin
            r_bytes_in_use <= pwdata[7:0];
        end
    end

    assign prdata  = (paddr[2] == REG_BYTES_IN_USE) ? {24'b0, r_bytes_in_use} : 32'b0;
    assign act_len = (r_bytes_in_use > 8'(MAP_BYTES)) ? 8'(MAP_BYTES) : r_bytes_in_use;

    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bra_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_len         (act_len),
        .i_mode        (i_mode),
        .i_bit_pos     (i_bit_pos),
        .i_value       (i_value),
        .i_run_length  (i_run_length),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_bit_value   (o_bit_value),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

`default_nettype wire
